/* src/ifs_pkg.sv */
`default_nettype none
package ifs_pkg;

  // Request type codes on the input channel.
  typedef enum logic [2:0] {
    REQ_VINT32 = 3'd0,
    REQ_VINT64 = 3'd1,
    REQ_INT32  = 3'd2,
    REQ_INT64  = 3'd3,
    REQ_CHAR   = 3'd4
  } req_type_e;

  localparam int unsigned ValW  = 64;
  localparam int unsigned TypeW = 3;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CntW  = 4;

  localparam logic [7:0]  VarMask   = 8'h7F;
  localparam logic [7:0]  VarMore   = 8'h80;
  localparam logic [7:0]  ChrLead2  = 8'hC0;
  localparam logic [7:0]  ChrLead3  = 8'hE0;
  localparam logic [7:0]  ChrCont   = 8'h80;
  localparam logic [15:0] ChrMax1   = 16'h007F;
  localparam logic [15:0] ChrMax2   = 16'h07FF;

  // What the shifter captures when an item is taken.
  typedef struct packed {
    logic             varint;  // 1: 7-bit groups low first, 0: bytes high first
    logic [ValW-1:0]  data;
    logic [CntW-1:0]  nbytes;  // byte count for the high-first form
  } load_t;

  // Control from the top level to the shifter.
  typedef struct packed {
    logic load;
    logic advance;
  } shift_ctl_t;

  // Turns a request into the shifter's starting contents.
  function automatic load_t build_load(logic [TypeW-1:0] t, logic [ValW-1:0] v);
    load_t       l;
    logic [15:0] c;
    l = '0;
    c = v[15:0];
    case (t)
      REQ_VINT32: begin
        l.varint = 1'b1;
        l.data   = {32'd0, v[31:0]};
      end
      REQ_VINT64: begin
        l.varint = 1'b1;
        l.data   = v;
      end
      REQ_INT32: begin
        l.data   = {v[31:0], 32'd0};
        l.nbytes = 4'd4;
      end
      REQ_INT64: begin
        l.data   = v;
        l.nbytes = 4'd8;
      end
      REQ_CHAR: begin
        if (c != 16'd0 && c <= ChrMax1) begin
          l.data   = {c[7:0], 56'd0};
          l.nbytes = 4'd1;
        end else if (c <= ChrMax2) begin
          l.data   = {ChrLead2 | {3'd0, c[10:6]}, ChrCont | {2'd0, c[5:0]}, 48'd0};
          l.nbytes = 4'd2;
        end else begin
          l.data   = {ChrLead3 | {4'd0, c[15:12]}, ChrCont | {2'd0, c[11:6]},
                      ChrCont | {2'd0, c[5:0]}, 40'd0};
          l.nbytes = 4'd3;
        end
      end
      default: l = '0;
    endcase
    return l;
  endfunction

  // True for the type codes that produce output.
  function automatic logic type_known(logic [TypeW-1:0] t);
    return t <= REQ_CHAR;
  endfunction

endpackage
`default_nettype wire

/* src/ifs_if.sv */
`default_nettype none
// Request channel: one typed value per beat.
interface ifs_req_if import ifs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TypeW-1:0] req_type;
  logic [ValW-1:0]  value;
  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

// Byte channel: one serialized byte per beat.
interface ifs_byte_if import ifs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             last;
  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface
`default_nettype wire

/* src/index_field_serializer.sv */
// A request is loaded into the shift register; each byte then passes through
// the output register before it is offered, one byte per cycle while that
// register is empty or being taken. A new request is taken while the last byte
// of the previous item still waits in the output register. Reset clears the
// busy flag, the output valid and the shifter's count and mode; data is not reset.
`default_nettype none
module index_field_serializer import ifs_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  ifs_req_if.sink     req,
  ifs_byte_if.source  rsp
);

  logic             busy_q, busy_d;
  logic             ovalid_q, ovalid_d;
  logic [ByteW-1:0] obyte_q;
  logic             olast_q;
  logic             accept;
  shift_ctl_t       ctl;
  load_t            load;
  logic [ByteW-1:0] sh_byte;
  logic             sh_last;

  assign req.ready = ~busy_q;
  assign accept    = req.valid & req.ready;
  assign load      = build_load(req.req_type, req.value);

  // Unknown type codes are taken and dropped without output.
  assign ctl.load    = accept & type_known(req.req_type);
  assign ctl.advance = busy_q & (~ovalid_q | rsp.ready);

  ifs_shreg u_shreg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .load_i (load),
    .byte_o (sh_byte),
    .last_o (sh_last)
  );

  // Busy from load until the final byte moves into the output register.
  always_comb begin
    busy_d = busy_q;
    if (ctl.advance && sh_last) begin
      busy_d = 1'b0;
    end
    if (ctl.load) begin
      busy_d = 1'b1;
    end
    ovalid_d = ovalid_q;
    if (ctl.advance) begin
      ovalid_d = 1'b1;
    end else if (rsp.ready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Output register holds the beat until it is taken.
  always_ff @(posedge clk_i) begin
    if (ctl.advance) begin
      obyte_q <= sh_byte;
      olast_q <= sh_last;
    end
  end

  assign rsp.valid    = ovalid_q;
  assign rsp.out_byte = obyte_q;
  assign rsp.last     = olast_q;

endmodule
`default_nettype wire

/* src/ifs_shreg.sv */
`default_nettype none
module ifs_shreg import ifs_pkg::*; (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  shift_ctl_t       ctl_i,
  input  load_t            load_i,
  output logic [ByteW-1:0] byte_o,
  output logic             last_o
);

  logic [ValW-1:0] sr_q, sr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            var_q, var_d;
  logic            more;

  // A varint group continues while any higher bit is still set.
  assign more   = |sr_q[ValW-1:7];
  assign byte_o = var_q ? ((sr_q[7:0] & VarMask) | (more ? VarMore : 8'd0))
                        : sr_q[ValW-1:ValW-ByteW];
  assign last_o = var_q ? ~more : (cnt_q == 4'd1);

  // Load on a new item, then one group or byte per advance.
  always_comb begin
    sr_d  = sr_q;
    cnt_d = cnt_q;
    var_d = var_q;
    if (ctl_i.load) begin
      sr_d  = load_i.data;
      cnt_d = load_i.nbytes;
      var_d = load_i.varint;
    end else if (ctl_i.advance) begin
      if (var_q) begin
        sr_d = sr_q >> 7;
      end else begin
        sr_d  = sr_q << ByteW;
        cnt_d = cnt_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      var_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      var_q <= var_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
  end

endmodule
`default_nettype wire

/* tb/tb_index_field_serializer.sv */
module tb_index_field_serializer;
  import ifs_pkg::*;

  localparam int unsigned RandomItems = 155;
  localparam int unsigned MaxGap      = 4;
  localparam int unsigned HoldAtBeat  = 300;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned IdleLimit   = 1000;

  // One request as queued for the driver; gap is the idle time after its beat.
  typedef struct {
    logic [TypeW-1:0] kind;
    logic [ValW-1:0]  value;
    int unsigned      gap;
  } req_item_t;

  // One serialized byte that the block must still produce.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } byte_exp_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic             req_valid = 1'b0;
  logic [TypeW-1:0] req_kind  = '0;
  logic [ValW-1:0]  req_value = '0;
  logic             rsp_ready = 1'b0;

  req_item_t   pending_reqs[$];
  byte_exp_t   expected_bytes[$];
  int unsigned send_gap_left;
  int unsigned recv_wait_left;
  int unsigned recv_beats;
  int unsigned idle_cycles;
  int unsigned err_count;

  ifs_req_if  req_if ();
  ifs_byte_if rsp_if ();

  assign req_if.valid    = req_valid;
  assign req_if.req_type = req_kind;
  assign req_if.value    = req_value;
  assign rsp_if.ready    = rsp_ready;

  index_field_serializer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_if),
    .rsp    (rsp_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string msg);
    $display("mismatch at beat %0d: %s", recv_beats, msg);
    err_count++;
  endtask

  // Computes the byte sequence that one request must produce and queues it.
  function automatic void serialize_request(input logic [TypeW-1:0] kind,
                                            input logic [ValW-1:0] v);
    logic [ValW-1:0]  u;
    logic [15:0]      c;
    logic [ByteW-1:0] seq[$];
    int               nb;
    case (kind)
      REQ_VINT32, REQ_VINT64: begin
        u = (kind == REQ_VINT32) ? {32'd0, v[31:0]} : v;
        while (u > 64'h7F) begin
          seq.push_back((u[7:0] & VarMask) | VarMore);
          u = u >> 7;
        end
        seq.push_back(u[7:0]);
      end
      REQ_INT32, REQ_INT64: begin
        nb = (kind == REQ_INT32) ? 4 : 8;
        for (int i = nb - 1; i >= 0; i--) begin
          u = v >> (8 * i);
          seq.push_back(u[7:0]);
        end
      end
      REQ_CHAR: begin
        c = v[15:0];
        if (c != 16'd0 && c <= ChrMax1) begin
          seq.push_back(c[7:0]);
        end else if (c <= ChrMax2) begin
          seq.push_back(ChrLead2 | {3'd0, c[10:6]});
          seq.push_back(ChrCont | {2'd0, c[5:0]});
        end else begin
          seq.push_back(ChrLead3 | {4'd0, c[15:12]});
          seq.push_back(ChrCont | {2'd0, c[11:6]});
          seq.push_back(ChrCont | {2'd0, c[5:0]});
        end
      end
      default: begin
      end
    endcase
    foreach (seq[i]) begin
      expected_bytes.push_back('{data: seq[i], last: (i == seq.size() - 1)});
    end
  endfunction

  // Compares one received byte beat with the oldest expected byte.
  task automatic check_beat(input logic [ByteW-1:0] got, input logic got_last);
    byte_exp_t want;
    if (expected_bytes.size() == 0) begin
      report_mismatch($sformatf("unexpected byte 0x%02h last=%0b", got, got_last));
      return;
    end
    want = expected_bytes.pop_front();
    if (got !== want.data) begin
      report_mismatch($sformatf("byte 0x%02h, expected 0x%02h", got, want.data));
    end
    if (got_last !== want.last) begin
      report_mismatch($sformatf("last %0b, expected %0b", got_last, want.last));
    end
  endtask

  function automatic void add_request(input logic [TypeW-1:0] kind,
                                      input logic [ValW-1:0] value,
                                      input int unsigned gap);
    pending_reqs.push_back('{kind: kind, value: value, gap: gap});
  endfunction

  // Random value shapes: full width, varied magnitude, top bits set, small low half.
  function automatic logic [ValW-1:0] random_value();
    logic [ValW-1:0] v;
    case ($urandom_range(0, 3))
      0: v = {$urandom, $urandom};
      1: v = {$urandom, $urandom} >> $urandom_range(0, 64);
      2: v = {$urandom, $urandom} | 64'h8000_0000_8000_0000;
      default: v = {$urandom, 32'd0} | 64'($urandom_range(0, 300));
    endcase
    return v;
  endfunction

  // Driver: offers queued requests, with the drawn idle time after each beat.
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    req_item_t item;
    if (!rst_ni) begin
      req_valid     <= 1'b0;
      req_kind      <= '0;
      req_value     <= '0;
      send_gap_left <= 0;
    end else begin
      if (req_valid && req_if.ready) begin
        serialize_request(req_kind, req_value);
      end
      if (!req_valid || req_if.ready) begin
        if (send_gap_left != 0) begin
          send_gap_left <= send_gap_left - 1;
          req_valid     <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          item          = pending_reqs.pop_front();
          req_valid     <= 1'b1;
          req_kind      <= item.kind;
          req_value     <= item.value;
          send_gap_left <= item.gap;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each byte beat and draws how long to hold off afterwards.
  always @(posedge clk_i or negedge rst_ni) begin : receive_bytes
    int unsigned hold;
    if (!rst_ni) begin
      rsp_ready      <= 1'b0;
      recv_wait_left <= 0;
      recv_beats     <= 0;
    end else begin
      if (rsp_if.valid && rsp_ready) begin
        check_beat(rsp_if.out_byte, rsp_if.last);
        recv_beats <= recv_beats + 1;
        if (recv_beats == HoldAtBeat) begin
          hold = HoldCycles;
        end else if (recv_beats % 200 < 50) begin
          hold = 0;
        end else begin
          hold = $urandom_range(0, MaxGap);
        end
        if (hold == 0) begin
          rsp_ready <= 1'b1;
        end else begin
          rsp_ready      <= 1'b0;
          recv_wait_left <= hold;
        end
      end else if (!rsp_ready) begin
        if (recv_wait_left <= 1) begin
          rsp_ready      <= 1'b1;
          recv_wait_left <= 0;
        end else begin
          recv_wait_left <= recv_wait_left - 1;
        end
      end
    end
  end

  // Counts cycles in which neither channel moves a beat.
  always @(posedge clk_i) begin
    if ((req_valid && req_if.ready) || (rsp_if.valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("tb_index_field_serializer: done, errors");
    $finish;
  end

  initial begin
    logic [TypeW-1:0] kind;
    int unsigned      drawn;
    int unsigned      draw;
    int unsigned      gap;
    err_count = 0;

    // Directed: varint boundaries, both widths, and values with top bit set.
    add_request(REQ_VINT32, 64'h0, $urandom_range(0, MaxGap));
    add_request(REQ_VINT32, 64'hFFFF_FFFF_0000_007F, $urandom_range(0, MaxGap));
    add_request(REQ_VINT32, 64'h0000_0000_0000_0080, $urandom_range(0, MaxGap));
    add_request(REQ_VINT32, 64'h1234_5678_FFFF_FFFF, $urandom_range(0, MaxGap));
    add_request(REQ_VINT64, 64'h0, $urandom_range(0, MaxGap));
    add_request(REQ_VINT64, 64'h0000_0000_0000_4000, $urandom_range(0, MaxGap));
    add_request(REQ_VINT64, 64'hFFFF_FFFF_FFFF_FFFF, $urandom_range(0, MaxGap));
    add_request(REQ_VINT64, 64'h8000_0000_0000_0000, $urandom_range(0, MaxGap));
    // Fixed-width integers, with junk above the 32-bit field.
    add_request(REQ_INT32, 64'h0, $urandom_range(0, MaxGap));
    add_request(REQ_INT32, 64'hA5A5_A5A5_FFFF_FFFF, $urandom_range(0, MaxGap));
    add_request(REQ_INT32, 64'hFFFF_FFFF_1234_5678, $urandom_range(0, MaxGap));
    add_request(REQ_INT64, 64'h0, $urandom_range(0, MaxGap));
    add_request(REQ_INT64, 64'hFFFF_FFFF_FFFF_FFFF, $urandom_range(0, MaxGap));
    add_request(REQ_INT64, 64'h0123_4567_89AB_CDEF, $urandom_range(0, MaxGap));
    // Characters: code zero in two bytes, each form's edges, a surrogate.
    add_request(REQ_CHAR, 64'hFFFF_FFFF_FFFF_0000, $urandom_range(0, MaxGap));
    add_request(REQ_CHAR, 64'h0000_0000_0000_0001, $urandom_range(0, MaxGap));
    add_request(REQ_CHAR, 64'h0000_0000_0000_007F, $urandom_range(0, MaxGap));
    add_request(REQ_CHAR, 64'h0000_0000_0000_0080, $urandom_range(0, MaxGap));
    add_request(REQ_CHAR, 64'h0000_0000_0000_07FF, $urandom_range(0, MaxGap));
    add_request(REQ_CHAR, 64'h0000_0000_0000_0800, $urandom_range(0, MaxGap));
    add_request(REQ_CHAR, 64'h5555_5555_5555_D800, $urandom_range(0, MaxGap));
    add_request(REQ_CHAR, 64'h0000_0000_0000_FFFF, $urandom_range(0, MaxGap));
    // Unused type codes produce nothing.
    add_request(3'd5, 64'hFFFF_FFFF_FFFF_FFFF, $urandom_range(0, MaxGap));
    add_request(3'd6, 64'h0, $urandom_range(0, MaxGap));
    add_request(3'd7, {$urandom, $urandom}, $urandom_range(0, MaxGap));

    // Random part, with a stretch of back-to-back requests.
    drawn = 0;
    while (drawn < RandomItems) begin
      draw = $urandom_range(0, 15);
      if (draw >= 13) begin
        kind = 3'($urandom_range(5, 7));
      end else begin
        kind = 3'(draw % 5);
      end
      gap = (drawn >= 60 && drawn < 100) ? 0 : $urandom_range(0, MaxGap);
      add_request(kind, random_value(), gap);
      drawn++;
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || req_valid) @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_count == 0) begin
      $display("tb_index_field_serializer: done, clean");
    end else begin
      $display("tb_index_field_serializer: done, errors");
    end
    $finish;
  end

endmodule
